>>> sv/cfc_pkg.sv
package cfc_pkg;

    localparam int MAX_JOINTS  = 16;
    localparam int IDX_W       = $clog2(MAX_JOINTS);
    localparam int FRAC_BITS   = 8;
    localparam int POS_W       = 24;
    localparam int STEP_PIXELS = 10;
    localparam int STEP_FIX    = STEP_PIXELS << FRAC_BITS;
    localparam int SPC_W       = 8 + FRAC_BITS;
    localparam int DIFF_W      = POS_W + 1;
    localparam int SQ_W        = 2 * DIFF_W;
    localparam int LEN_W       = DIFF_W;
    localparam int NUM_W       = DIFF_W + SPC_W + 1;
    localparam int SUM_W       = POS_W + 2;
    localparam int ENT_W       = 2 * POS_W;

    localparam logic [2:0] DIR_UP    = 3'd1;
    localparam logic [2:0] DIR_DOWN  = 3'd2;
    localparam logic [2:0] DIR_LEFT  = 3'd3;
    localparam logic [2:0] DIR_RIGHT = 3'd4;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_MOVE = 1'b1;

    localparam logic REG_COUNT   = 1'b0;
    localparam logic REG_SPACING = 1'b1;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [ENT_W-1:0] wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } mem_req_t;

    typedef enum logic [4:0] {
        S_IDLE, S_HRD, S_HOUT, S_EMIT, S_RD, S_DIFF, S_SQX, S_SQY,
        S_SQS, S_SQW, S_MULX, S_DVXS, S_DVXW, S_MULY, S_DVYS, S_DVYW, S_WR
    } state_t;

    function automatic logic [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        begin
            hi = SUM_W'((1 << (POS_W - 1)) - 1);
            lo = -SUM_W'(1 << (POS_W - 1));
            if (v > hi)
                sat_pos = hi[POS_W-1:0];
            else if (v < lo)
                sat_pos = lo[POS_W-1:0];
            else
                sat_pos = v[POS_W-1:0];
        end
    endfunction

endpackage

>>> sv/cfc_mem.sv
module cfc_mem (
    input  logic                      clk,
    input  logic                      rst_n,
    input  cfc_pkg::mem_req_t         req,
    output logic [cfc_pkg::ENT_W-1:0] rdata
);
    import cfc_pkg::*;

    logic [ENT_W-1:0]      mem [MAX_JOINTS];
    logic [MAX_JOINTS-1:0] vld_reg;
    logic [ENT_W-1:0]      rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
            mem[req.waddr] <= req.wdata;
        if (req.re)
            rdata_reg <= mem[req.raddr];
    end

    logic rvld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            rvld_reg <= 1'b0;
        end
        else
        begin
            if (req.we)
                vld_reg[req.waddr] <= 1'b1;
            if (req.re)
                rvld_reg <= vld_reg[req.raddr];
        end
    end

    assign rdata = rvld_reg ? rdata_reg : '0;

endmodule

>>> sv/cfc_sqrt.sv
module cfc_sqrt (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [cfc_pkg::SQ_W-1:0]  rad,
    output logic                      done,
    output logic [cfc_pkg::LEN_W-1:0] root
);
    import cfc_pkg::*;

    localparam int K_W = $clog2(LEN_W);

    logic [SQ_W-1:0] v_reg;
    logic [SQ_W:0]   r_reg;
    logic [K_W-1:0]  k_reg;
    logic            busy_reg;
    logic            done_reg;
    logic [SQ_W:0]   bitv;
    logic [SQ_W:0]   trial;

    assign bitv  = (SQ_W + 1)'(1) << {k_reg, 1'b0};
    assign trial = r_reg + bitv;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg <= rad;
            r_reg <= '0;
            k_reg <= K_W'(LEN_W - 1);
        end
        else if (busy_reg)
        begin
            if ({1'b0, v_reg} >= trial)
            begin
                v_reg <= SQ_W'({1'b0, v_reg} - trial);
                r_reg <= (r_reg >> 1) + bitv;
            end
            else
                r_reg <= r_reg >> 1;
            k_reg <= k_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && (k_reg == '0);
            if (start)
                busy_reg <= 1'b1;
            else if (busy_reg && (k_reg == '0))
                busy_reg <= 1'b0;
        end
    end

    assign done = done_reg;
    assign root = r_reg[LEN_W-1:0];

endmodule

>>> sv/cfc_div.sv
module cfc_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [cfc_pkg::NUM_W-1:0] num,
    input  logic [cfc_pkg::LEN_W-1:0] den,
    output logic                      done,
    output logic [cfc_pkg::NUM_W-1:0] quot
);
    import cfc_pkg::*;

    localparam int C_W = $clog2(NUM_W);

    logic [NUM_W-1:0] q_reg;
    logic [LEN_W:0]   rem_reg;
    logic [LEN_W-1:0] den_reg;
    logic [C_W-1:0]   cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [LEN_W:0]   rem_sh;
    logic             fits;

    assign rem_sh = {rem_reg[LEN_W-1:0], q_reg[NUM_W-1]};
    assign fits   = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= num;
            rem_reg <= '0;
            den_reg <= den;
            cnt_reg <= C_W'(NUM_W - 1);
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? rem_sh - {1'b0, den_reg} : rem_sh;
            q_reg   <= {q_reg[NUM_W-2:0], fits};
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == '0);
            if (start)
                busy_reg <= 1'b1;
            else if (busy_reg && (cnt_reg == '0))
                busy_reg <= 1'b0;
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

>>> sv/chain_follow_constraint_core.sv
// chain of joint positions, signed fixed point with 8 fraction bits
// input channel s_axis: tuser is the op, 0 load and 1 move; a load writes
// one joint and gives no item, a move shifts the head 10 pixels and gives
// one output item per joint in use, head first, tlast on the tail joint
// output channel m_axis: tuser is the zero-link flag
// config port: cfg_we writes cfg_data into register cfg_index
// (0 joint count, 1 joint spacing); the user must write only while no move
// is in progress, the block itself does not enforce it; a move reads the head,
// writes it back moved and then offers the head item; each following joint
// takes the 25-step square root and the two 42-step divisions, both skipped
// for a zero-length link, plus the wait for each output item to be taken
// only one item is in work at a time; s_axis_tready is low from the
// accept of a move until its tail item has been taken
// a stall on m_axis holds the current output item and the walk with it
// reset makes all joints read as zero, sets count to 2 and spacing to 16
module chain_follow_constraint_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,  // load_index, load_x, load_y, direction, zero pad
    input  logic        s_axis_tuser,  // op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,  // joint_number, pos_x, pos_y, zero pad
    output logic        m_axis_tuser,  // zero_link
    output logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);
    import cfc_pkg::*;

    state_t state_reg, state_next;

    logic [4:0]       count_reg;
    logic [7:0]       spacing_reg;
    logic [IDX_W-1:0] j_reg;
    logic [IDX_W-1:0] lastj_reg;
    logic [2:0]       dir_reg;
    logic [POS_W-1:0] px_reg, py_reg;
    logic [POS_W-1:0] cx_reg, cy_reg;
    logic [DIFF_W-1:0] magx_reg, magy_reg;
    logic              sgnx_reg, sgny_reg;
    logic [SQ_W-1:0]   sq_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [NUM_W-1:0]  qx_reg;
    logic              zl_reg;

    logic              out_valid_reg;
    logic [IDX_W-1:0]  out_j_reg;
    logic [POS_W-1:0]  out_x_reg, out_y_reg;
    logic              out_zl_reg, out_last_reg;

    mem_req_t          req;
    logic [ENT_W-1:0]  rdata;
    logic              sq_start, sq_done, dv_start, dv_done;
    logic [LEN_W-1:0]  len;
    logic [NUM_W-1:0]  quot;

    logic              in_acc, out_acc;
    logic [POS_W-1:0]  rd_x, rd_y;
    logic signed [SUM_W-1:0] hx, hy, nx, ny;
    logic [POS_W-1:0]  hxs, hys, nxs, nys;
    logic signed [DIFF_W-1:0] dx, dy;
    logic [NUM_W-1:0]  mul_x, mul_y;
    logic [SPC_W-1:0]  s_fix;

    cfc_mem u_mem (.clk(clk), .rst_n(rst_n), .req(req), .rdata(rdata));

    cfc_sqrt u_sqrt (.clk(clk), .rst_n(rst_n), .start(sq_start), .rad(sq_reg),
                     .done(sq_done), .root(len));

    cfc_div u_div (.clk(clk), .rst_n(rst_n), .start(dv_start), .num(num_reg),
                   .den(len), .done(dv_done), .quot(quot));

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;
    assign rd_x    = rdata[POS_W-1:0];
    assign rd_y    = rdata[ENT_W-1:POS_W];
    assign s_fix   = {spacing_reg, FRAC_BITS'(0)};

    // head move
    always_comb
    begin
        hx = SUM_W'($signed(rd_x));
        hy = SUM_W'($signed(rd_y));
        unique case (dir_reg)
            DIR_UP:    hy = hy - SUM_W'(STEP_FIX);
            DIR_DOWN:  hy = hy + SUM_W'(STEP_FIX);
            DIR_LEFT:  hx = hx - SUM_W'(STEP_FIX);
            DIR_RIGHT: hx = hx + SUM_W'(STEP_FIX);
            default:   ;
        endcase
        hxs = sat_pos(hx);
        hys = sat_pos(hy);
    end

    assign dx = DIFF_W'($signed(rd_x)) - DIFF_W'($signed(px_reg));
    assign dy = DIFF_W'($signed(rd_y)) - DIFF_W'($signed(py_reg));

    assign mul_x = NUM_W'(magx_reg * s_fix) + NUM_W'(len >> 1);
    assign mul_y = NUM_W'(magy_reg * s_fix) + NUM_W'(len >> 1);

    assign nx = sgnx_reg ? SUM_W'($signed(px_reg)) - SUM_W'(qx_reg[SPC_W:0])
                         : SUM_W'($signed(px_reg)) + SUM_W'(qx_reg[SPC_W:0]);
    assign ny = sgny_reg ? SUM_W'($signed(py_reg)) - SUM_W'(quot[SPC_W:0])
                         : SUM_W'($signed(py_reg)) + SUM_W'(quot[SPC_W:0]);
    assign nxs = zl_reg ? cx_reg : sat_pos(nx);
    assign nys = zl_reg ? cy_reg : sat_pos(ny);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_acc && s_axis_tuser == OP_MOVE) state_next = S_HRD;
            S_HRD:  state_next = S_HOUT;
            S_HOUT: state_next = S_EMIT;
            S_EMIT:
            begin
                if (out_acc)
                    state_next = out_last_reg ? S_IDLE : S_RD;
            end
            S_RD:   state_next = S_DIFF;
            S_DIFF: state_next = S_SQX;
            S_SQX:  state_next = S_SQY;
            S_SQY:  state_next = (magx_reg == '0 && magy_reg == '0) ? S_WR : S_SQS;
            S_SQS:  state_next = S_SQW;
            S_SQW:  if (sq_done) state_next = S_MULX;
            S_MULX: state_next = S_DVXS;
            S_DVXS: state_next = S_DVXW;
            S_DVXW: if (dv_done) state_next = S_MULY;
            S_MULY: state_next = S_DVYS;
            S_DVYS: state_next = S_DVYW;
            S_DVYW: if (dv_done) state_next = S_WR;
            S_WR:   state_next = S_EMIT;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        req       = '0;
        sq_start  = 1'b0;
        dv_start  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req.we    = in_acc && s_axis_tuser == OP_LOAD;
                req.waddr = s_axis_tdata[IDX_W-1:0];
                req.wdata = {s_axis_tdata[51:28], s_axis_tdata[27:4]};
            end
            S_HRD:
            begin
                req.re    = 1'b1;
                req.raddr = '0;
            end
            S_HOUT:
            begin
                req.we    = 1'b1;
                req.waddr = '0;
                req.wdata = {hys, hxs};
            end
            S_RD:
            begin
                req.re    = 1'b1;
                req.raddr = j_reg;
            end
            S_SQS:  sq_start = 1'b1;
            S_DVXS: dv_start = 1'b1;
            S_DVYS: dv_start = 1'b1;
            S_WR:
            begin
                req.we    = 1'b1;
                req.waddr = j_reg;
                req.wdata = {nys, nxs};
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= 5'd2;
            spacing_reg   <= 8'd16;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_COUNT:   count_reg   <= cfg_data[4:0];
                    REG_SPACING: spacing_reg <= cfg_data;
                endcase
            end
            if (state_reg == S_HOUT || state_reg == S_WR)
                out_valid_reg <= 1'b1;
            else if (out_acc)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                dir_reg <= s_axis_tdata[54:52];
                j_reg   <= '0;
                if (count_reg < 5'd2)
                    lastj_reg <= IDX_W'(1);
                else if (count_reg > 5'(MAX_JOINTS))
                    lastj_reg <= IDX_W'(MAX_JOINTS - 1);
                else
                    lastj_reg <= IDX_W'(count_reg - 5'd1);
            end
            S_HOUT:
            begin
                px_reg       <= hxs;
                py_reg       <= hys;
                out_j_reg    <= '0;
                out_x_reg    <= hxs;
                out_y_reg    <= hys;
                out_zl_reg   <= 1'b0;
                out_last_reg <= 1'b0;
            end
            S_EMIT: if (out_acc) j_reg <= j_reg + 1'b1;
            S_DIFF:
            begin
                cx_reg   <= rd_x;
                cy_reg   <= rd_y;
                sgnx_reg <= dx[DIFF_W-1];
                sgny_reg <= dy[DIFF_W-1];
                magx_reg <= dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
                magy_reg <= dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
            end
            S_SQX: sq_reg <= magx_reg * magx_reg;
            S_SQY:
            begin
                sq_reg <= sq_reg + SQ_W'(magy_reg * magy_reg);
                zl_reg <= (magx_reg == '0 && magy_reg == '0);
            end
            S_MULX: num_reg <= mul_x;
            S_DVXW: if (dv_done) qx_reg <= quot;
            S_MULY: num_reg <= mul_y;
            S_WR:
            begin
                px_reg       <= nxs;
                py_reg       <= nys;
                out_j_reg    <= j_reg;
                out_x_reg    <= nxs;
                out_y_reg    <= nys;
                out_zl_reg   <= zl_reg;
                out_last_reg <= (j_reg == lastj_reg);
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, out_y_reg, out_x_reg, out_j_reg};
    assign m_axis_tuser  = out_zl_reg;
    assign m_axis_tlast  = out_last_reg;

`ifndef SYNTHESIS
    a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken while an output item waits");
    a_tail_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
        else $error("walk did not end after the tail item");
    a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WR) |-> !m_axis_tvalid)
        else $error("new joint result over an untaken item");
`endif

endmodule
